// ----- rtl/core/pcpfl_pkg.sv -----
// ----------------------------------------------------------------------------
// pcpfl_pkg
// Shared types and codes for the per-CPU page free-list allocator.
// ----------------------------------------------------------------------------
package pcpfl_pkg;

    // request kinds
    localparam logic ACT_FREE  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // configuration register indexes
    localparam logic CFG_HEAP_LOW  = 1'b0;
    localparam logic CFG_HEAP_HIGH = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_FREE   = 5'b00100,
        S_HEAD   = 5'b01000,
        S_LINK   = 5'b10000
    } state_t;

endpackage

// ----- rtl/core/pcpfl_ram.sv -----
// ----------------------------------------------------------------------------
// pcpfl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcpfl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// ----- rtl/core/per_cpu_page_free_list_allocator.sv -----
// ----------------------------------------------------------------------------
// per_cpu_page_free_list_allocator
// Page allocator with one LIFO free list per CPU; allocate steals from the
// lowest-numbered non-empty list when the requester's own list is empty.
// ----------------------------------------------------------------------------
//  channel   | signals                              | flow
//  ----------+--------------------------------------+-------------------------
//  request   | start, busy, action, cpu, page_addr  | taken on start && !busy
//  result    | done, result_addr, status            | one cycle, no backpressure
//  config    | cfg_we, cfg_index, cfg_data          | write on cfg_we
//
//  Free: decode, then head/link write-back.
//  Allocate: decode, head RAM read, link RAM read, write-back; decode only
//  when every list is empty. The two RAM reads of a pop are dependent.
//  Result strobes in the cycle after the last state; the next request may be
//  taken in that same cycle. Reset empties all lists at once (valid flops).
// ----------------------------------------------------------------------------
module per_cpu_page_free_list_allocator #(
    parameter int CPU_COUNT  = 8,
    parameter int MAX_PAGES  = 32768,
    parameter int PAGE_BYTES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [2:0]  cpu,
    input  logic [31:0] page_addr,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [31:0] result_addr,
    output logic [1:0]  status
);

    import pcpfl_pkg::*;

    localparam int CPU_W   = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int IDX_W   = $clog2(MAX_PAGES);
    localparam int OFF_W   = $clog2(PAGE_BYTES);
    localparam int FRAME_W = 32 - OFF_W;
    localparam int BASE_W  = FRAME_W + 1;
    localparam int DIFF_W  = (BASE_W > IDX_W) ? BASE_W : IDX_W + 1;

    // cpu number folded into range; at most eight narrow subtract steps
    function automatic logic [CPU_W-1:0] cpu_wrap(input logic [2:0] v);
        logic [6:0] r;
        r = {4'd0, v};
        for (int k = 0; k < 8; k++)
        begin
            if (r >= 7'(CPU_COUNT))
            begin
                r = r - 7'(CPU_COUNT);
            end
        end
        return CPU_W'(r);
    endfunction

    state_t                state_reg, state_next;
    logic [CPU_COUNT-1:0]  valid_reg, valid_next;
    logic [31:0]           heap_low_reg, heap_high_reg;
    logic                  done_reg, done_next;
    logic [1:0]            status_reg, status_next;
    logic [31:0]           result_addr_reg, result_addr_next;

    logic                  action_reg, action_next;
    logic [CPU_W-1:0]      cpu_reg, cpu_next;
    logic [31:0]           addr_reg, addr_next;
    logic                  bad_reg, bad_next;
    logic [DIFF_W-1:0]     diff_reg, diff_next;
    logic [CPU_W-1:0]      tgt_reg, tgt_next;
    logic [IDX_W-1:0]      head_idx_reg, head_idx_next;

    logic [32:0]           low_round;
    logic [BASE_W-1:0]     base_frame;
    logic [DIFF_W-1:0]     diff;
    logic                  addr_bad;
    logic [IDX_W-1:0]      free_idx;
    logic                  over_range;
    logic [CPU_W-1:0]      low_cpu;
    logic [CPU_W-1:0]      tgt;
    logic                  any_valid;
    logic [FRAME_W-1:0]    out_frame;

    logic                  head_we;
    logic [CPU_W-1:0]      head_waddr, head_raddr;
    logic [IDX_W-1:0]      head_wdata, head_rdata;
    logic                  link_we;
    logic [IDX_W-1:0]      link_wdata, link_raddr, link_rdata;

    pcpfl_ram #(.WIDTH(IDX_W), .DEPTH(CPU_COUNT)) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    pcpfl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PAGES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (free_idx),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // first whole page at or above heap_low
    assign low_round  = {1'b0, heap_low_reg} + 33'(PAGE_BYTES - 1);
    assign base_frame = low_round[32:OFF_W];

    assign diff     = DIFF_W'(addr_reg[31:OFF_W]) - DIFF_W'(base_frame);
    assign addr_bad = (addr_reg[OFF_W-1:0] != '0) || (addr_reg < heap_low_reg)
                      || (addr_reg >= heap_high_reg);
    assign free_idx   = diff_reg[IDX_W-1:0];
    assign over_range = diff_reg >= DIFF_W'(MAX_PAGES);

    // steal target: own list if non-empty, else lowest non-empty list
    always_comb
    begin
        low_cpu   = '0;
        any_valid = |valid_reg;
        for (int i = CPU_COUNT - 1; i >= 0; i--)
        begin
            if (valid_reg[i])
            begin
                low_cpu = CPU_W'(i);
            end
        end
        tgt = valid_reg[cpu_reg] ? cpu_reg : low_cpu;
    end

    assign head_raddr = (action_reg == ACT_ALLOC) ? tgt : cpu_reg;
    assign link_raddr = head_rdata;
    assign out_frame  = FRAME_W'(base_frame) + FRAME_W'(head_idx_reg);

    always_comb
    begin
        state_next       = state_reg;
        valid_next       = valid_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        result_addr_next = result_addr_reg;
        action_next      = action_reg;
        cpu_next         = cpu_reg;
        addr_next        = addr_reg;
        bad_next         = bad_reg;
        diff_next        = diff_reg;
        tgt_next         = tgt_reg;
        head_idx_next    = head_idx_reg;
        head_we          = 1'b0;
        head_waddr       = cpu_reg;
        head_wdata       = free_idx;
        link_we          = 1'b0;
        link_wdata       = valid_reg[cpu_reg] ? head_rdata : free_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next = action;
                    cpu_next    = cpu_wrap(cpu);
                    addr_next   = page_addr;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (action_reg == ACT_FREE)
                begin
                    bad_next   = addr_bad;
                    diff_next  = diff;
                    state_next = S_FREE;
                end
                else if (!any_valid)
                begin
                    done_next        = 1'b1;
                    status_next      = STATUS_EMPTY;
                    result_addr_next = '0;
                    state_next       = S_IDLE;
                end
                else
                begin
                    tgt_next   = tgt;
                    state_next = S_HEAD;
                end
            end
            S_FREE:
            begin
                done_next        = 1'b1;
                result_addr_next = '0;
                if (bad_reg || over_range)
                begin
                    status_next = STATUS_BAD;
                end
                else
                begin
                    status_next         = STATUS_OK;
                    link_we             = 1'b1;
                    head_we             = 1'b1;
                    valid_next[cpu_reg] = 1'b1;
                end
                state_next = S_IDLE;
            end
            S_HEAD:
            begin
                head_idx_next = head_rdata;
                state_next    = S_LINK;
            end
            S_LINK:
            begin
                // a page that links to itself ends its list
                if (link_rdata == head_idx_reg)
                begin
                    valid_next[tgt_reg] = 1'b0;
                end
                else
                begin
                    head_we    = 1'b1;
                    head_waddr = tgt_reg;
                    head_wdata = link_rdata;
                end
                done_next        = 1'b1;
                status_next      = STATUS_OK;
                result_addr_next = {out_frame, OFF_W'(0)};
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            valid_reg       <= '0;
            done_reg        <= 1'b0;
            status_reg      <= STATUS_OK;
            result_addr_reg <= '0;
            heap_low_reg    <= 32'h8000_0000;
            heap_high_reg   <= 32'h8800_0000;
        end
        else
        begin
            state_reg       <= state_next;
            valid_reg       <= valid_next;
            done_reg        <= done_next;
            status_reg      <= status_next;
            result_addr_reg <= result_addr_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_HEAP_LOW:  heap_low_reg  <= cfg_data;
                    CFG_HEAP_HIGH: heap_high_reg <= cfg_data;
                    default:       heap_low_reg  <= heap_low_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        cpu_reg      <= cpu_next;
        addr_reg     <= addr_next;
        bad_reg      <= bad_next;
        diff_reg     <= diff_next;
        tgt_reg      <= tgt_next;
        head_idx_reg <= head_idx_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign result_addr = result_addr_reg;

    // a result always follows a request in flight
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg != S_IDLE))
        else $error("result strobe without a request in flight");

    // an accepted free marks its list non-empty
    a_free_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FREE && !bad_reg && !over_range) |=> valid_reg[$past(cpu_reg)])
        else $error("free did not mark list non-empty");

    // empty status only when every list is empty
    a_empty_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == STATUS_EMPTY) |-> (valid_reg == '0))
        else $error("empty status with a non-empty list");

    // failing results carry a zero address
    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg != STATUS_OK) |-> (result_addr_reg == '0))
        else $error("nonzero address on a failed request");

    // a pop only reaches the link read with a listed target
    a_pop_target_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HEAD) |-> valid_reg[tgt_reg])
        else $error("pop from an empty list");

endmodule

// ----- dv/tb_per_cpu_page_free_list_allocator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_per_cpu_page_free_list_allocator
// Self-checking bench for the per-CPU page free-list allocator. Directed
// requests cover the address checks, stealing, double frees and heap bounds
// moved at their extremes. Random traffic then runs over several heap windows
// with sender gaps. Each result is checked against a local model of the lists.
// ----------------------------------------------------------------------------
module tb_per_cpu_page_free_list_allocator;
    import pcpfl_pkg::*;

    localparam int CPUS      = 8;
    localparam int PAGES     = 32768;
    localparam int PG_BYTES  = 4096;
    localparam int PHASE_LEN = 525;
    localparam int WINDOWS   = 5;

    typedef struct packed {
        logic [31:0] addr;
        logic [1:0]  st;
    } page_reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        action;
    logic [2:0]  cpu;
    logic [31:0] page_addr;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        done;
    logic [31:0] result_addr;
    logic [1:0]  status;

    per_cpu_page_free_list_allocator #(
        .CPU_COUNT  (CPUS),
        .MAX_PAGES  (PAGES),
        .PAGE_BYTES (PG_BYTES)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .cpu         (cpu),
        .page_addr   (page_addr),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .result_addr (result_addr),
        .status      (status)
    );

    // local copy of the allocator state
    logic [31:0] heap_lo;
    logic [31:0] heap_hi;
    logic        list_live [CPUS];
    logic [14:0] list_top  [CPUS];
    logic [14:0] page_next [PAGES];

    page_reply_t owed_replies [$];

    int errors;
    int gap_pct;
    int n_handed;
    int n_empty;
    int n_pushed;
    int n_rejected;
    int n_reg_writes;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("timeout: allocator stopped answering");
        $display("per_cpu_page_free_list_allocator test failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic longint unsigned first_frame();
        longint unsigned f;
        f = 64'(heap_lo);
        return (f + PG_BYTES - 1) / PG_BYTES;
    endfunction

    function automatic logic take_page(input logic [2:0] c, output logic [14:0] pg);
        pg = list_top[c];
        if (!list_live[c])
            return 1'b0;
        // a page linked to itself ends its list
        if (page_next[pg] == pg)
            list_live[c] = 1'b0;
        else
            list_top[c] = page_next[pg];
        return 1'b1;
    endfunction

    function automatic page_reply_t predict_reply(input logic act, input logic [2:0] c,
                                                  input logic [31:0] a);
        page_reply_t     r;
        longint unsigned base;
        longint unsigned idx;
        logic [14:0]     pg;
        logic            got;
        int              i;
        base   = first_frame();
        r.addr = '0;
        r.st   = STATUS_OK;
        if (act == ACT_FREE) begin
            if (a % PG_BYTES != 0 || a < heap_lo || a >= heap_hi) begin
                r.st = STATUS_BAD;
            end
            else begin
                idx = 64'(a / PG_BYTES);
                idx = idx - base;
                if (idx >= PAGES) begin
                    r.st = STATUS_BAD;
                end
                else begin
                    page_next[idx[14:0]] = list_live[c] ? list_top[c] : idx[14:0];
                    list_top[c]          = idx[14:0];
                    list_live[c]         = 1'b1;
                end
            end
        end
        else begin
            got = take_page(c, pg);
            // steal from the lowest-numbered other non-empty list
            for (i = 0; i < CPUS && !got; i++) begin
                if (i != c)
                    got = take_page(3'(i), pg);
            end
            if (!got)
                r.st = STATUS_EMPTY;
            else
                r.addr = 32'((base + pg) * PG_BYTES);
        end
        return r;
    endfunction

    always @(negedge clk)
    begin : check_reply
        page_reply_t want;
        if (rst_n && done === 1'b1) begin
            if (owed_replies.size() == 0) begin
                report_mismatch($sformatf("result addr %08h status %0d with no request open",
                                          result_addr, status));
            end
            else begin
                want = owed_replies.pop_front();
                if (result_addr !== want.addr)
                    report_mismatch($sformatf("result_addr %08h, expected %08h",
                                              result_addr, want.addr));
                if (status !== want.st)
                    report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
            end
        end
    end

    task automatic send_request(input logic act, input logic [2:0] c, input logic [31:0] a);
        logic        taken;
        page_reply_t r;
        while ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        action    <= act;
        cpu       <= c;
        page_addr <= a;
        taken = 1'b0;
        while (!taken) begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        r = predict_reply(act, c, a);
        owed_replies.push_back(r);
        if (act == ACT_ALLOC) begin
            if (r.st == STATUS_OK)
                n_handed++;
            else
                n_empty++;
        end
        else begin
            if (r.st == STATUS_OK)
                n_pushed++;
            else
                n_rejected++;
        end
    endtask

    // sender holds off until every open request has been answered
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (owed_replies.size() != 0 || busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_HEAP_LOW)
            heap_lo = val;
        else
            heap_hi = val;
        n_reg_writes++;
    endtask

    task automatic test_reset_defaults();
        send_request(ACT_ALLOC, 3'd0, 32'h0000_0000);
        send_request(ACT_FREE,  3'd7, 32'h8000_0000);
        send_request(ACT_FREE,  3'd0, 32'h87FF_F000);
        send_request(ACT_FREE,  3'd0, 32'h8800_0000);   // at heap_high
        send_request(ACT_FREE,  3'd0, 32'h7FFF_F000);   // below heap_low
        send_request(ACT_FREE,  3'd0, 32'h8000_0800);   // not page aligned
        send_request(ACT_FREE,  3'd3, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 3'd0, 32'hFFFF_FFFF);
        send_request(ACT_ALLOC, 3'd3, 32'h0000_0000);   // own list empty, steals
        send_request(ACT_FREE,  3'd5, 32'h8000_1000);
        send_request(ACT_FREE,  3'd2, 32'h8000_2000);
        send_request(ACT_ALLOC, 3'd7, 32'h0000_0000);   // lowest other list wins
    endtask

    task automatic test_double_free();
        send_request(ACT_FREE,  3'd4, 32'h8000_3000);
        send_request(ACT_FREE,  3'd4, 32'h8000_3000);
        send_request(ACT_ALLOC, 3'd4, 32'h0000_0000);
        send_request(ACT_ALLOC, 3'd4, 32'h0000_0000);
    endtask

    task automatic test_heap_bounds();
        write_reg(CFG_HEAP_LOW,  32'h0000_0000);
        write_reg(CFG_HEAP_HIGH, 32'hFFFF_FFFF);
        send_request(ACT_FREE, 3'd6, 32'h0000_0000);
        send_request(ACT_FREE, 3'd6, 32'h07FF_F000);    // last page index
        send_request(ACT_FREE, 3'd6, 32'h0800_0000);    // one page past capacity
        // listed pages keep their index; addresses rebuild from the new base and wrap
        write_reg(CFG_HEAP_LOW, 32'hFFFF_F000);
        send_request(ACT_ALLOC, 3'd6, 32'h0000_0000);
        send_request(ACT_ALLOC, 3'd1, 32'h0000_0000);
        send_request(ACT_FREE,  3'd7, 32'hFFFF_F000);
        send_request(ACT_ALLOC, 3'd0, 32'h0000_0000);
        write_reg(CFG_HEAP_LOW,  32'h0000_1001);        // base rounds up a page
        write_reg(CFG_HEAP_HIGH, 32'h0000_0000);
        send_request(ACT_FREE, 3'd2, 32'h0000_2000);
        write_reg(CFG_HEAP_HIGH, 32'h0000_3000);
        send_request(ACT_FREE,  3'd2, 32'h0000_1000);
        send_request(ACT_FREE,  3'd2, 32'h0000_2000);
        send_request(ACT_FREE,  3'd2, 32'h0000_3000);
        send_request(ACT_ALLOC, 3'd2, 32'h0000_0000);
    endtask

    task automatic pick_random_window();
        longint unsigned lo;
        longint unsigned hi;
        lo = 64'($urandom);
        if ($urandom_range(1))
            lo[11:0] = '0;
        case ($urandom_range(7))
            0: lo = 0;
            1: lo[31:28] = 4'hF;
            default: ;
        endcase
        hi = lo + 64'($urandom_range(40000, 16)) * PG_BYTES;
        if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
        if ($urandom_range(9) == 0)
            hi = 64'($urandom);
        write_reg(CFG_HEAP_LOW,  32'(lo));
        write_reg(CFG_HEAP_HIGH, 32'(hi));
    endtask

    task automatic send_random_request();
        longint unsigned base;
        longint unsigned top;
        longint unsigned lim;
        longint unsigned span;
        int unsigned     hi_idx;
        int              pick;
        logic [2:0]      c;
        logic [31:0]     a;
        base = first_frame();
        top  = 64'(heap_hi);
        top  = (top + PG_BYTES - 1) / PG_BYTES;
        lim  = base + PAGES;
        if (top < lim)
            lim = top;
        if (lim > 64'h10_0000)
            lim = 64'h10_0000;
        span = (lim > base) ? lim - base : 0;
        pick = $urandom_range(99);
        c    = 3'($urandom_range(7));
        a    = $urandom;
        if (pick < 45) begin
            send_request(ACT_ALLOC, c, a);
        end
        else begin
            if ($urandom_range(1))
                c[2] = 1'b0;
            if (pick < 90 && span != 0) begin
                // small pool half the time so pages get freed twice
                hi_idx = 32'(span - 1);
                if (hi_idx > 63 && $urandom_range(1))
                    hi_idx = 63;
                a = 32'((base + $urandom_range(hi_idx)) * PG_BYTES);
            end
            else begin
                case ($urandom_range(3))
                    0: ;
                    1: a = {heap_hi[31:12], 12'h000};
                    2: a = {heap_lo[31:12], 12'h000} | 32'($urandom_range(PG_BYTES - 1, 1));
                    default: a = 32'(lim * PG_BYTES);
                endcase
            end
            send_request(ACT_FREE, c, a);
        end
    endtask

    task automatic test_random_traffic(input int pct);
        gap_pct = pct;
        for (int w = 0; w < WINDOWS; w++) begin
            pick_random_window();
            for (int n = 0; n < PHASE_LEN / WINDOWS; n++) begin
                if ($urandom_range(63) == 0)
                    wait_idle();
                send_random_request();
            end
        end
    endtask

    initial
    begin
        int guard;
        errors       = 0;
        n_handed     = 0;
        n_empty      = 0;
        n_pushed     = 0;
        n_rejected   = 0;
        n_reg_writes = 0;
        gap_pct      = 31;
        heap_lo      = 32'h8000_0000;
        heap_hi      = 32'h8800_0000;
        foreach (list_live[i]) begin
            list_live[i] = 1'b0;
            list_top[i]  = '0;
        end
        rst_n     <= 1'b0;
        start     <= 1'b0;
        action    <= ACT_FREE;
        cpu       <= '0;
        page_addr <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_HEAP_LOW;
        cfg_data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_double_free();
        test_heap_bounds();
        test_random_traffic(31);
        test_random_traffic(75);
        test_random_traffic(0);

        start <= 1'b0;
        guard = 0;
        while (owed_replies.size() != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        if (owed_replies.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", owed_replies.size()));
        repeat (10) @(posedge clk);

        $display("Covered %0d requests across %0d register writes.",
                 n_handed + n_empty + n_pushed + n_rejected, n_reg_writes);
        $display("Pages handed out %0d, empty allocates %0d, frees pushed %0d, rejected %0d.",
                 n_handed, n_empty, n_pushed, n_rejected);
        if (errors == 0)
            $display("per_cpu_page_free_list_allocator test passed");
        else
            $display("per_cpu_page_free_list_allocator test failed");
        $finish;
    end

endmodule
